### hdl/vsseq_pkg.sv
// Shared types and constants for the valve setpoint step sequencer.
// No dependencies; imported by the controller, the datapath and the top level.
package vsseq_pkg;

  localparam int TEMP_W = 6;
  localparam int MODE_W = 3;
  localparam int TGT_W  = 8;

  // Command codes carried on the input tuser
  localparam logic [MODE_W-1:0] MODE_SET     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INC     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DEC     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_OFF     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RESTORE = 3'd4;

  // Configuration register indexes
  localparam logic REG_MIN_TEMP = 1'b0;
  localparam logic REG_MAX_TEMP = 1'b1;

  // Reset values
  localparam logic [TEMP_W-1:0] MIN_TEMP_RST = 6'd7;
  localparam logic [TEMP_W-1:0] MAX_TEMP_RST = 6'd30;
  localparam logic [TEMP_W-1:0] LAST_ON_RST  = 6'd20;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // latch the plan of the accepted command
    logic step;   // emit one encoder step
    logic stat;   // emit the status item
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic cnt_zero;  // no steps left
    logic out_free;  // output register can take an item
  } dp_sts_t;

endpackage

### hdl/vsseq_ctrl.sv
// Controller FSM for the valve setpoint step sequencer.
// Depends on vsseq_pkg for the command and status structs.
module vsseq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  vsseq_pkg::dp_sts_t sts,
  output vsseq_pkg::dp_cmd_t cmd
);
  import vsseq_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_STEP = 2'd1;
  localparam logic [1:0] ST_STAT = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Sequence: accept, emit steps until the count runs out, emit status
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        if (sts.cnt_zero) begin
          state_nxt = ST_STAT;
        end else if (sts.out_free) begin
          cmd.step = 1'b1;
        end
      end
      ST_STAT: begin
        if (sts.out_free) begin
          cmd.stat  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hdl/vsseq_dp.sv
// Datapath for the valve setpoint step sequencer: limits, setpoint state,
// step counter and output register. Depends on vsseq_pkg.
module vsseq_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic                           cfg_addr,
  input  logic [vsseq_pkg::TEMP_W-1:0]   cfg_wdata,
  input  logic [vsseq_pkg::MODE_W-1:0]   in_mode,
  input  logic [vsseq_pkg::TGT_W-1:0]    in_target,
  input  vsseq_pkg::dp_cmd_t             cmd,
  output vsseq_pkg::dp_sts_t             sts,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,
  output logic                           out_tuser,
  output logic                           out_tlast
);
  import vsseq_pkg::*;

  logic [TEMP_W-1:0] min_r, max_r;
  logic [TEMP_W-1:0] sp_r, sp_nxt;
  logic [TEMP_W-1:0] lo_r, lo_nxt;
  logic [TEMP_W-1:0] cnt_r, plan_cnt;
  logic              up_r, plan_up;
  logic [TGT_W-1:0]  t_sel;
  logic [TEMP_W-1:0] t_sat;
  logic              go_off;
  logic              ov_r;
  logic              ov_step_r;
  logic              ov_up_r;
  logic [TEMP_W-1:0] ov_temp_r;

  // Raise into the on range, then cap at the maximum
  function automatic logic [TEMP_W-1:0] clamp_sp(input logic [TEMP_W:0]   v,
                                                 input logic [TEMP_W-1:0] mn,
                                                 input logic [TEMP_W-1:0] mx);
    logic [TEMP_W:0] w;
    w = v;
    if (w != '0 && w < {1'b0, mn}) w = {1'b0, mn};
    if (w > {1'b0, mx}) w = {1'b0, mx};
    return w[TEMP_W-1:0];
  endfunction

  // Saturate the target (request or saved setpoint) at max_temp
  always_comb begin
    t_sel = (in_mode == MODE_RESTORE) ? {{(TGT_W-TEMP_W){1'b0}}, lo_r} : in_target;
    t_sat = (t_sel > {{(TGT_W-TEMP_W){1'b0}}, max_r}) ? max_r : t_sel[TEMP_W-1:0];
  end

  // Plan the step run and the new state for the incoming command
  always_comb begin
    plan_cnt = '0;
    plan_up  = 1'b0;
    sp_nxt   = sp_r;
    lo_nxt   = lo_r;
    go_off   = (in_mode == MODE_OFF) ||
               (((in_mode == MODE_SET) || (in_mode == MODE_RESTORE)) && (t_sat < min_r));
    if (go_off) begin
      plan_cnt = max_r;
      lo_nxt   = sp_r;
      sp_nxt   = '0;
    end else begin
      case (in_mode)
        MODE_SET, MODE_RESTORE: begin
          if (sp_r == '0) begin
            plan_cnt = t_sat - min_r;
            plan_up  = 1'b1;
          end else if (t_sat > sp_r) begin
            plan_cnt = t_sat - sp_r;
            plan_up  = 1'b1;
          end else begin
            plan_cnt = sp_r - t_sat;
          end
          sp_nxt = t_sat;
        end
        MODE_INC: begin
          plan_cnt = 6'd1;
          plan_up  = 1'b1;
          sp_nxt   = clamp_sp({1'b0, sp_r} + 7'd1, min_r, max_r);
        end
        MODE_DEC: begin
          plan_cnt = 6'd1;
          if (sp_r != '0) sp_nxt = clamp_sp({1'b0, sp_r} - 7'd1, min_r, max_r);
        end
        default: begin
        end
      endcase
    end
  end

  // Limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= MIN_TEMP_RST;
      max_r <= MAX_TEMP_RST;
    end else if (cfg_we) begin
      if (cfg_addr == REG_MIN_TEMP) min_r <= cfg_wdata;
      if (cfg_addr == REG_MAX_TEMP) max_r <= cfg_wdata;
    end
  end

  // Setpoint state and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r  <= '0;
      lo_r  <= LAST_ON_RST;
      cnt_r <= '0;
    end else if (cmd.load) begin
      sp_r  <= sp_nxt;
      lo_r  <= lo_nxt;
      cnt_r <= plan_cnt;
    end else if (cmd.step) begin
      cnt_r <= cnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) up_r <= plan_up;
  end

  // Output register: load a step or the status, drop on transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.step || cmd.stat) begin
      ov_r <= 1'b1;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      ov_step_r <= 1'b1;
      ov_up_r   <= up_r;
      ov_temp_r <= '0;
    end else if (cmd.stat) begin
      ov_step_r <= 1'b0;
      ov_up_r   <= 1'b0;
      ov_temp_r <= sp_r;
    end
  end

  assign sts.cnt_zero = (cnt_r == '0);
  assign sts.out_free = !ov_r || out_tready;

  assign out_tvalid = ov_r;
  assign out_tdata  = {1'b0, ov_temp_r, ov_up_r};
  assign out_tuser  = ov_step_r;
  assign out_tlast  = !ov_step_r;

endmodule

### hdl/valve_setpoint_step_sequencer.sv
// Valve setpoint step sequencer: top level joining controller and datapath.
// Depends on vsseq_pkg, vsseq_ctrl and vsseq_dp.
//
// Usage: each input transaction carries a command on in_tuser (0 set,
// 1 increment, 2 decrement, 3 off, 4 restore) and a target on in_tdata.
// The block answers with a run of encoder steps (out_tuser = 1, direction
// in out_tdata[0]) and closes it with one status transaction (out_tuser = 0,
// out_tlast = 1) whose out_tdata[6:1] holds the new setpoint, 0 for off.
// min_temp and max_temp are written through cfg_we/cfg_addr/cfg_wdata.
//
// Timing: one command is handled at a time. A command has n steps, with
// n at most 63, emitted one step per cycle while the receiver does not
// stall. The step counter in the datapath sets that bound. in_tready is
// high while the controller is idle, also while the last status still
// waits.
//
// Reset: the setpoint is off, the saved setpoint is 20, the limits are
// 7 and 30, and no output is pending. When out_tready is low the output
// register holds its item and the sequencer waits before the next one.
module valve_setpoint_step_sequencer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic                         cfg_addr,   // 0 min_temp, 1 max_temp
  input  logic [vsseq_pkg::TEMP_W-1:0] cfg_wdata,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // [7:0] target_temp
  input  logic [2:0]                   in_tuser,   // [2:0] mode
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [7:0]                   out_tdata,  // [0] step_up, [6:1] current_temp, [7] zero
  output logic                         out_tuser,  // [0] step_valid
  output logic                         out_tlast
);
  import vsseq_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  vsseq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  vsseq_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_mode    (in_tuser),
    .in_target  (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

### hdl/vsseq_chk.sv
// Port-level checker for the valve setpoint step sequencer, bound to the top.
// Depends only on the top level's ports.
module vsseq_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tuser,
  input logic       out_tlast
);

  // Status item carries no step and no direction
  a_stat_fmt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> !out_tuser && !out_tdata[0])
    else $error("status item with step fields set");

  // Step items never close a run and carry no setpoint
  a_step_fmt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> !out_tlast && out_tdata[7:1] == 7'd0)
    else $error("step item with status fields set");

  // Reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // Stalled output holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled output changed");

endmodule

bind valve_setpoint_step_sequencer vsseq_chk u_chk (.*);
